>>> sv/imu_cal_pkg.sv
// types and constants shared by the imu calibration and integration block
package imu_cal_pkg;

    localparam int CAL_SAMPLES = 1000;
    localparam int CNT_W       = 16;
    localparam int CFG_W       = 15;
    localparam int AXES        = 3;
    localparam int BIAS_N      = 2 * AXES;
    localparam int SUM_W       = 32;
    localparam int ANGLE_W     = 48;
    localparam int DT_W        = 20;

    // truncating divide by CAL_SAMPLES as a multiply by a rounded-up reciprocal
    localparam int DIV_L     = $clog2(CAL_SAMPLES);
    localparam int DIV_SHIFT = SUM_W + DIV_L;
    localparam logic [SUM_W:0] DIV_RECIP = (SUM_W + 1)'(
        ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    localparam logic [CNT_W-1:0] CAL_COUNT = CNT_W'(CAL_SAMPLES);
    localparam logic [CFG_W-1:0] GRAVITY_RST  = CFG_W'(16384);
    localparam logic [CFG_W-1:0] DEADBAND_RST = CFG_W'(131);

    typedef logic [2:0] t_bias_idx;
    localparam t_bias_idx BIAS_LAST = t_bias_idx'(BIAS_N - 1);

    typedef enum logic {
        CMD_CAL  = 1'b0,
        CMD_MEAS = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_GRAVITY  = 1'b0,
        REG_DEADBAND = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [DT_W-1:0]    dt_q20;
    } t_imu_in;

    typedef struct packed {
        logic                      measured;
        logic                      calibrated;
        logic signed [15:0]        accel_g_x;
        logic signed [15:0]        accel_g_y;
        logic signed [15:0]        accel_g_z;
        logic signed [15:0]        rate_x;
        logic signed [15:0]        rate_y;
        logic signed [15:0]        rate_z;
        logic signed [ANGLE_W-1:0] angle_x;
        logic signed [ANGLE_W-1:0] angle_y;
        logic signed [ANGLE_W-1:0] angle_z;
    } t_imu_out;

endpackage

>>> sv/imu_offset_calibrate_and_integrate.sv
// Six-axis imu bias calibration and gyro integration. Calibration beats (cmd 0) add
// into per-axis sums with gravity taken off accel Z; after CAL_SAMPLES of them each
// bias becomes its sum divided by CAL_SAMPLES, truncated toward zero. Measurement
// beats (cmd 1) subtract the biases and add corrected gyro times dt into 48-bit angles
// for every axis whose corrected rate magnitude is above the deadband. One beat is
// taken per clock, unless the output stalls or a bias divide is running, through an
// input register and a result register. After the beat that completes a calibration
// pass, the next beat is held in the input register while the six biases go one at
// a time through a single registered reciprocal multiplier (32 x 33 bits).
module imu_offset_calibrate_and_integrate
    import imu_cal_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_imu_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_imu_out         o_out_data,
    input  logic             i_cfg_wr_en,
    input  t_reg_idx         i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_gravity;
    logic [CFG_W-1:0] r_deadband;

    logic                      r_in_vld;
    t_imu_in                   r_in;
    logic                      r_out_vld;
    t_imu_out                  r_out;

    logic signed [SUM_W-1:0]   r_sum   [BIAS_N];
    logic signed [15:0]        r_bias  [BIAS_N];
    logic signed [ANGLE_W-1:0] r_angle [AXES];
    logic [CNT_W-1:0]          r_count;
    logic                      r_cal_done;

    // bias divide sequencer
    logic             r_div_run;
    t_bias_idx        r_div_idx;
    logic             r_s1_vld;
    t_bias_idx        r_s1_idx;
    logic             r_s1_neg;
    logic [SUM_W-1:0] r_s1_mag;
    logic             r_s2_vld;
    t_bias_idx        r_s2_idx;
    logic             r_s2_neg;
    logic [2*SUM_W:0] r_s2_prod;

    logic                      w_busy;
    logic                      w_adv;
    logic signed [15:0]        w_acc  [AXES];
    logic signed [15:0]        w_gyr  [AXES];
    logic signed [SUM_W-1:0]   w_sample [BIAS_N];
    logic signed [SUM_W-1:0]   n_sum  [BIAS_N];
    logic [CNT_W-1:0]          w_cnt_inc;
    logic                      w_pass_end;
    logic signed [15:0]        w_ca   [AXES];
    logic signed [15:0]        w_cg   [AXES];
    logic [15:0]               w_mag  [AXES];
    logic signed [36:0]        w_inc  [AXES];
    logic signed [ANGLE_W-1:0] n_angle [AXES];
    logic signed [SUM_W-1:0]   w_div_sum;
    logic [15:0]               w_quot;
    t_imu_out                  n_out;

    assign w_busy = r_div_run | r_s1_vld | r_s2_vld;
    assign w_adv  = r_in_vld & (~r_out_vld | ~i_out_stall) & ~w_busy;

    assign o_in_stall  = r_in_vld & ~w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_acc[0] = r_in.accel_x;
    assign w_acc[1] = r_in.accel_y;
    assign w_acc[2] = r_in.accel_z;
    assign w_gyr[0] = r_in.gyro_x;
    assign w_gyr[1] = r_in.gyro_y;
    assign w_gyr[2] = r_in.gyro_z;

    assign w_cnt_inc  = r_count + CNT_W'(1);
    assign w_pass_end = (w_cnt_inc == CAL_COUNT);

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_sample[i]        = SUM_W'(w_acc[i]);
            w_sample[AXES + i] = SUM_W'(w_gyr[i]);
        end
        // gravity comes off accel Z
        w_sample[2] = SUM_W'(w_acc[2]) - SUM_W'({1'b0, r_gravity});
        for (int i = 0; i < BIAS_N; i++) begin
            n_sum[i] = r_sum[i] + w_sample[i];
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_ca[i]  = w_acc[i] - r_bias[i];
            w_cg[i]  = w_gyr[i] - r_bias[AXES + i];
            w_mag[i] = w_cg[i][15] ? 16'(-w_cg[i]) : 16'(w_cg[i]);
            w_inc[i] = w_cg[i] * $signed({1'b0, r_in.dt_q20});
            if (w_mag[i] > {1'b0, r_deadband}) begin
                n_angle[i] = r_angle[i] + {{(ANGLE_W - 37){w_inc[i][36]}}, w_inc[i]};
            end else begin
                n_angle[i] = r_angle[i];
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (r_in.cmd == CMD_MEAS) begin
            n_out.measured   = 1'b1;
            n_out.calibrated = r_cal_done;
            n_out.accel_g_x  = w_ca[0];
            n_out.accel_g_y  = w_ca[1];
            n_out.accel_g_z  = w_ca[2];
            n_out.rate_x     = w_cg[0];
            n_out.rate_y     = w_cg[1];
            n_out.rate_z     = w_cg[2];
            n_out.angle_x    = n_angle[0];
            n_out.angle_y    = n_angle[1];
            n_out.angle_z    = n_angle[2];
        end else begin
            n_out.calibrated = r_cal_done | w_pass_end;
        end
    end

    assign w_div_sum = r_sum[r_div_idx];
    assign w_quot    = r_s2_prod[DIV_SHIFT +: 16];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity  <= GRAVITY_RST;
            r_deadband <= DEADBAND_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_GRAVITY:  r_gravity  <= i_cfg_data;
                REG_DEADBAND: r_deadband <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in_valid & ~o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid & ~o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // calibration, bias and angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BIAS_N; i++) begin
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
            for (int i = 0; i < AXES; i++) begin
                r_angle[i] <= '0;
            end
            r_count    <= '0;
            r_cal_done <= 1'b0;
            r_div_run  <= 1'b0;
            r_div_idx  <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
        end else begin
            if (w_adv) begin
                if (r_in.cmd == CMD_CAL) begin
                    // the final sums stay put until the divide has read them
                    for (int i = 0; i < BIAS_N; i++) begin
                        r_sum[i] <= n_sum[i];
                    end
                    if (w_pass_end) begin
                        r_count    <= '0;
                        r_cal_done <= 1'b1;
                        r_div_run  <= 1'b1;
                        r_div_idx  <= '0;
                    end else begin
                        r_count <= w_cnt_inc;
                    end
                end else begin
                    for (int i = 0; i < AXES; i++) begin
                        r_angle[i] <= n_angle[i];
                    end
                end
            end

            r_s1_vld <= r_div_run;
            if (r_div_run) begin
                if (r_div_idx == BIAS_LAST) begin
                    r_div_run <= 1'b0;
                end else begin
                    r_div_idx <= r_div_idx + t_bias_idx'(1);
                end
            end
            r_s2_vld <= r_s1_vld;

            if (r_s2_vld) begin
                r_bias[r_s2_idx] <= r_s2_neg ? 16'(-w_quot) : w_quot;
                if (r_s2_idx == BIAS_LAST) begin
                    for (int i = 0; i < BIAS_N; i++) begin
                        r_sum[i] <= '0;
                    end
                end
            end
        end
    end

    // divide datapath: sign and magnitude, reciprocal product (the sign is restored on the bias write)
    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_div_idx;
        r_s1_neg  <= w_div_sum[SUM_W-1];
        r_s1_mag  <= w_div_sum[SUM_W-1] ? SUM_W'(-w_div_sum) : SUM_W'(w_div_sum);
        r_s2_idx  <= r_s1_idx;
        r_s2_neg  <= r_s1_neg;
        r_s2_prod <= r_s1_mag * DIV_RECIP;
    end

endmodule
